/* rtl/core/bpc_pkg.sv */
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; every other file refers to it by scoped names.
package bpc_pkg;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } req_payload_type;

   typedef struct packed {
      logic signed [14:0] temp_centideg;
      logic [24:0]        press_pa_q8;
      logic               press_valid;
   } rsp_payload_type;

   // Trim words as raw 16-bit fields; signed ones are extended where used.
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } trim_type;

   localparam int TrimW = 48;

   localparam logic [1:0] REG_TEMP_TRIM    = 2'd0;
   localparam logic [1:0] REG_PRESS_TRIM_A = 2'd1;
   localparam logic [1:0] REG_PRESS_TRIM_B = 2'd2;
   localparam logic [1:0] REG_PRESS_TRIM_C = 2'd3;

   localparam logic signed [26:0] TF_OFFSET = 27'sd128000;
   localparam logic signed [20:0] TEMP_MIN  = -21'sd4000;
   localparam logic signed [20:0] TEMP_MAX  = 21'sd8500;
   localparam logic [63:0]        PRESS_MAX = 64'd33554431;
   localparam logic [63:0]        PRESS_BIAS = 64'h0000_8000_0000_0000;
   localparam logic [63:0]        NUM_SCALE = 64'd3125;
   localparam logic [20:0]        PRESS_FULL = 21'd1048576;

   localparam int DivSteps = 64;

   localparam logic [1:0] SKID_FULL = 2'd2;

   typedef struct packed {
      logic [30:0]        rem;
      logic [63:0]        dq;
      logic [30:0]        mb;
      logic               qneg;
      logic               zero;
      logic signed [14:0] temp;
   } div_stage_type;

endpackage

/* rtl/core/bpc_temp.sv */
// Temperature stages: fine temperature t_fine and saturated centidegrees.
// Uses bpc_pkg types; four register stages.
module bpc_temp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_vld,
   input  bpc_pkg::req_payload_type in_data,
   input  bpc_pkg::trim_type        trim,
   output logic                     out_vld,
   output logic signed [25:0]       out_tf,
   output logic signed [14:0]       out_temp,
   output logic [19:0]              out_adc_p
);

   logic [3:0]         vld_ff;
   logic [19:0]        adcp_ff [4];

   logic signed [17:0] x_dif;
   logic signed [16:0] d_dif;
   logic signed [33:0] dd_full;
   logic signed [33:0] ta1_in, ta1_ff;
   logic [31:0]        dd1_in, dd1_ff;
   logic signed [22:0] ta2_in, ta2_ff;
   logic signed [36:0] tb2_in, tb2_ff;
   logic signed [25:0] tf3_in, tf3_ff;
   logic signed [25:0] tf4_ff;
   logic signed [28:0] t5;
   logic signed [20:0] tc;
   logic signed [14:0] temp4_in, temp4_ff;

   always_comb begin
      x_dif = $signed({1'b0, in_data.raw_temperature[19:3]}) - $signed({1'b0, trim.t1, 1'b0});
      d_dif = $signed({1'b0, in_data.raw_temperature[19:4]}) - $signed({1'b0, trim.t1});
      ta1_in = $signed({{16{x_dif[17]}}, x_dif}) * $signed({{18{trim.t2[15]}}, trim.t2});
      dd_full = $signed({{17{d_dif[16]}}, d_dif}) * $signed({{17{d_dif[16]}}, d_dif});
      dd1_in = dd_full[31:0];

      tb2_in = $signed({17'b0, dd1_ff[31:12]}) * $signed({{21{trim.t3[15]}}, trim.t3});
      ta2_in = ta1_ff[33:11];

      tf3_in = $signed({{3{ta2_ff[22]}}, ta2_ff}) + $signed({{3{tb2_ff[36]}}, tb2_ff[36:14]});

      t5 = $signed({{3{tf3_ff[25]}}, tf3_ff}) * 29'sd5 + 29'sd128;
      tc = t5[28:8];
      if (tc < bpc_pkg::TEMP_MIN) begin
         temp4_in = bpc_pkg::TEMP_MIN[14:0];
      end else if (tc > bpc_pkg::TEMP_MAX) begin
         temp4_in = bpc_pkg::TEMP_MAX[14:0];
      end else begin
         temp4_in = tc[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_vld};
      end
      if (en) begin
         ta1_ff     <= ta1_in;
         dd1_ff     <= dd1_in;
         ta2_ff     <= ta2_in;
         tb2_ff     <= tb2_in;
         tf3_ff     <= tf3_in;
         tf4_ff     <= tf3_ff;
         temp4_ff   <= temp4_in;
         adcp_ff[0] <= in_data.raw_pressure;
         for (int i = 1; i < 4; i++) begin
            adcp_ff[i] <= adcp_ff[i-1];
         end
      end
   end

   assign out_vld   = vld_ff[3];
   assign out_tf    = tf4_ff;
   assign out_temp  = temp4_ff;
   assign out_adc_p = adcp_ff[3];

endmodule

/* rtl/core/bpc_pcoef.sv */
// Pressure coefficient stages: builds the 64-bit dividend and the divisor.
// Uses bpc_pkg types; five register stages, all products wrap modulo 2^64.
module bpc_pcoef (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic signed [25:0]  in_tf,
   input  logic signed [14:0]  in_temp,
   input  logic [19:0]         in_adc_p,
   input  bpc_pkg::trim_type   trim,
   output logic                out_vld,
   output logic [63:0]         out_num,
   output logic [30:0]         out_den,
   output logic signed [14:0]  out_temp
);

   logic [4:0]         vld_ff;
   logic signed [14:0] temp_ff [5];
   logic [19:0]        adcp_ff [3];

   logic signed [26:0] a_dif;
   logic signed [53:0] aa1_in, aa1_ff;
   logic signed [42:0] ap5_in, ap5_ff1, ap5_ff2;
   logic signed [42:0] ap2_in, ap2_ff1, ap2_ff2;
   logic [63:0]        aa64;
   logic [63:0]        b6_in, b6_ff;
   logic [63:0]        ap3_in, ap3_ff;
   logic [63:0]        ap3_sh;
   logic [63:0]        bsum_in, bsum_ff;
   logic [63:0]        a2_in, a2_ff;
   logic [20:0]        pdif;
   logic [63:0]        a3_in, a3_ff;
   logic [63:0]        pn_in, pn_ff;
   logic [63:0]        num_in, num_ff;
   logic [30:0]        den_ff;

   always_comb begin
      a_dif  = $signed({in_tf[25], in_tf}) - bpc_pkg::TF_OFFSET;
      aa1_in = $signed({{27{a_dif[26]}}, a_dif}) * $signed({{27{a_dif[26]}}, a_dif});
      ap5_in = $signed({{16{a_dif[26]}}, a_dif}) * $signed({{27{trim.p5[15]}}, trim.p5});
      ap2_in = $signed({{16{a_dif[26]}}, a_dif}) * $signed({{27{trim.p2[15]}}, trim.p2});

      aa64   = {{10{aa1_ff[53]}}, aa1_ff};
      b6_in  = aa64 * {{48{trim.p6[15]}}, trim.p6};
      ap3_in = aa64 * {{48{trim.p3[15]}}, trim.p3};

      ap3_sh  = $signed(ap3_ff) >>> 8;
      bsum_in = b6_ff + ({{21{ap5_ff2[42]}}, ap5_ff2} << 17)
                + ({{48{trim.p4[15]}}, trim.p4} << 35);
      a2_in   = ap3_sh + ({{21{ap2_ff2[42]}}, ap2_ff2} << 12);

      a3_in = (bpc_pkg::PRESS_BIAS + a2_ff) * {48'b0, trim.p1};
      pdif  = bpc_pkg::PRESS_FULL - {1'b0, adcp_ff[2]};
      pn_in = {12'b0, pdif, 31'b0} - bsum_ff;

      num_in = pn_ff * bpc_pkg::NUM_SCALE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_vld};
      end
      if (en) begin
         aa1_in_capture: begin
         end
         aa1_ff  <= aa1_in;
         ap5_ff1 <= ap5_in;
         ap2_ff1 <= ap2_in;
         b6_ff   <= b6_in;
         ap3_ff  <= ap3_in;
         ap5_ff2 <= ap5_ff1;
         ap2_ff2 <= ap2_ff1;
         bsum_ff <= bsum_in;
         a2_ff   <= a2_in;
         a3_ff   <= a3_in;
         pn_ff   <= pn_in;
         num_ff  <= num_in;
         den_ff  <= a3_ff[63:33];
         temp_ff[0] <= in_temp;
         for (int i = 1; i < 5; i++) begin
            temp_ff[i] <= temp_ff[i-1];
         end
         adcp_ff[0] <= in_adc_p;
         for (int i = 1; i < 3; i++) begin
            adcp_ff[i] <= adcp_ff[i-1];
         end
      end
   end

   assign out_vld  = vld_ff[4];
   assign out_num  = num_ff;
   assign out_den  = den_ff;
   assign out_temp = temp_ff[4];

endmodule

/* rtl/core/bpc_div.sv */
// Pipelined signed 64-by-31-bit divider, one quotient bit per stage.
// Uses bpc_pkg::div_stage_type; truncates toward zero, flags a zero divisor.
module bpc_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  logic [63:0]        in_num,
   input  logic [30:0]        in_den,
   input  logic signed [14:0] in_temp,
   output logic               out_vld,
   output logic [63:0]        out_q,
   output logic               out_zero,
   output logic signed [14:0] out_temp
);

   localparam int Steps = bpc_pkg::DivSteps;

   logic [Steps:0]          vld_ff;
   bpc_pkg::div_stage_type  st_ff [Steps+1];
   bpc_pkg::div_stage_type  st_in [Steps+1];
   logic [31:0]             shifted [Steps];
   logic [32:0]             diff [Steps];

   logic [63:0]             q_in, q_ff;
   logic                    zero_ff;
   logic signed [14:0]      temp_ff;
   logic                    vld_out_ff;

   always_comb begin
      // operand magnitudes; the most negative dividend maps to 2^63, which fits
      st_in[0].rem  = '0;
      st_in[0].dq   = in_num[63] ? (64'd0 - in_num) : in_num;
      st_in[0].mb   = in_den[30] ? (31'd0 - in_den) : in_den;
      st_in[0].qneg = in_num[63] ^ in_den[30];
      st_in[0].zero = (in_den == 31'd0);
      st_in[0].temp = in_temp;
      for (int i = 0; i < Steps; i++) begin
         shifted[i] = {st_ff[i].rem, st_ff[i].dq[63]};
         diff[i]    = {1'b0, shifted[i]} - {2'b0, st_ff[i].mb};
         st_in[i+1] = st_ff[i];
         st_in[i+1].rem = diff[i][32] ? shifted[i][30:0] : diff[i][30:0];
         st_in[i+1].dq  = {st_ff[i].dq[62:0], ~diff[i][32]};
      end
      q_in = st_ff[Steps].qneg ? (64'd0 - st_ff[Steps].dq) : st_ff[Steps].dq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         vld_out_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[Steps-1:0], in_vld};
         vld_out_ff <= vld_ff[Steps];
      end
      if (en) begin
         for (int i = 0; i <= Steps; i++) begin
            st_ff[i] <= st_in[i];
         end
         q_ff    <= q_in;
         zero_ff <= st_ff[Steps].zero;
         temp_ff <= st_ff[Steps].temp;
      end
   end

   assign out_vld  = vld_out_ff;
   assign out_q    = q_ff;
   assign out_zero = zero_ff;
   assign out_temp = temp_ff;

endmodule

/* rtl/core/bpc_ppost.sv */
// Post-division pressure correction with P7..P9 and output saturation.
// Uses bpc_pkg types; six register stages, products wrap modulo 2^64.
module bpc_ppost (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_vld,
   input  logic [63:0]              in_q,
   input  logic                     in_zero,
   input  logic signed [14:0]       in_temp,
   input  bpc_pkg::trim_type        trim,
   output logic                     out_vld,
   output bpc_pkg::rsp_payload_type out_data
);

   logic [5:0]         vld_ff;
   logic [4:0]         zero_ff;
   logic signed [14:0] temp_ff [5];

   logic [63:0] sh1, sh2;
   logic [63:0] x1_in, x1_ff;
   logic [63:0] p8p1_in, p8p1_ff;
   logic [63:0] q1_ff;
   logic [63:0] m0_in, m0_ff;
   logic [31:0] m1_in, m1_ff;
   logic [31:0] m2_in, m2_ff;
   logic [63:0] b8;
   logic [63:0] bq2_in, bq2_ff, bq3_ff;
   logic [63:0] prod3_in, prod3_ff;
   logic [63:0] a9;
   logic [63:0] s4_in, s4_ff;
   logic [63:0] s8;
   logic [63:0] r5_in, r5_ff;
   bpc_pkg::rsp_payload_type out_in, out_ff;

   always_comb begin
      sh1     = $signed(in_q) >>> 13;
      x1_in   = sh1 * {{48{trim.p9[15]}}, trim.p9};
      p8p1_in = in_q * {{48{trim.p8[15]}}, trim.p8};

      // low 64 bits of x * sh from three 32-bit partial products
      sh2    = $signed(q1_ff) >>> 13;
      m0_in  = {32'b0, x1_ff[31:0]} * {32'b0, sh2[31:0]};
      m1_in  = x1_ff[63:32] * sh2[31:0];
      m2_in  = x1_ff[31:0] * sh2[63:32];
      b8     = $signed(p8p1_ff) >>> 19;
      bq2_in = q1_ff + b8;

      prod3_in = m0_ff + {m1_ff + m2_ff, 32'b0};

      a9    = $signed(prod3_ff) >>> 25;
      s4_in = bq3_ff + a9;

      s8    = $signed(s4_ff) >>> 8;
      r5_in = s8 + ({{48{trim.p7[15]}}, trim.p7} << 4);

      // zero flag and temperature sit at the same stage as r5_ff
      out_in.temp_centideg = temp_ff[4];
      if (zero_ff[4]) begin
         out_in.press_pa_q8 = '0;
         out_in.press_valid = 1'b0;
      end else begin
         out_in.press_valid = 1'b1;
         if (r5_ff[63]) begin
            out_in.press_pa_q8 = '0;
         end else if (r5_ff > bpc_pkg::PRESS_MAX) begin
            out_in.press_pa_q8 = bpc_pkg::PRESS_MAX[24:0];
         end else begin
            out_in.press_pa_q8 = r5_ff[24:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_vld};
      end
      if (en) begin
         x1_ff    <= x1_in;
         p8p1_ff  <= p8p1_in;
         q1_ff    <= in_q;
         m0_ff    <= m0_in;
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         bq2_ff   <= bq2_in;
         prod3_ff <= prod3_in;
         bq3_ff   <= bq2_ff;
         s4_ff    <= s4_in;
         r5_ff    <= r5_in;
         out_ff   <= out_in;
         zero_ff  <= {zero_ff[3:0], in_zero};
         temp_ff[0] <= in_temp;
         for (int i = 1; i < 5; i++) begin
            temp_ff[i] <= temp_ff[i-1];
         end
      end
   end

   assign out_vld  = vld_ff[5];
   assign out_data = out_ff;

endmodule

/* rtl/core/baro_temp_press_compensation.sv */
// Barometric temperature/pressure compensation, fully pipelined.
// Channels: req_* carries one pair of raw 20-bit readings per transfer, rsp_*
// returns the compensated temperature (0.01 degC), pressure (Pa, Q17.8) and a
// pressure valid flag. A transfer happens when valid is high and stall is low.
// Throughput: one reading per cycle while req_stall is low; every stage advances together.
// The 64-stage restoring divider (one quotient bit per stage) makes up most
// of the pipeline depth from the input transfer to rsp_valid.
// The trim words sit in four 48-bit registers written through csr_*; write
// them only while no reading is in flight.
// A two-entry output buffer lets the pipeline keep accepting while one
// result waits; req_stall rises only when both entries are full and the
// receiver stalls, and then the whole pipeline holds with nothing lost.
// Synchronous reset empties the pipeline and the output buffer and clears
// all trim registers to zero.
// Depends on bpc_pkg, bpc_temp, bpc_pcoef, bpc_div and bpc_ppost.
module baro_temp_press_compensation (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bpc_pkg::req_payload_type    req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bpc_pkg::rsp_payload_type    rsp_payload,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [bpc_pkg::TrimW-1:0]   csr_wdata
);

   logic [bpc_pkg::TrimW-1:0] temp_trim_ff, press_a_ff, press_b_ff, press_c_ff;
   bpc_pkg::trim_type         trim;

   logic                      adv;

   logic                      t_vld;
   logic signed [25:0]        t_tf;
   logic signed [14:0]        t_temp;
   logic [19:0]               t_adc_p;
   logic                      c_vld;
   logic [63:0]               c_num;
   logic [30:0]               c_den;
   logic signed [14:0]        c_temp;
   logic                      d_vld;
   logic [63:0]               d_q;
   logic                      d_zero;
   logic signed [14:0]        d_temp;
   logic                      p_vld;
   bpc_pkg::rsp_payload_type  p_data;

   logic [1:0]                cnt_in, cnt_ff;
   bpc_pkg::rsp_payload_type  buf0_in, buf0_ff, buf1_in, buf1_ff;
   logic                      push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff <= '0;
         press_a_ff   <= '0;
         press_b_ff   <= '0;
         press_c_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bpc_pkg::REG_TEMP_TRIM:    temp_trim_ff <= csr_wdata;
            bpc_pkg::REG_PRESS_TRIM_A: press_a_ff   <= csr_wdata;
            bpc_pkg::REG_PRESS_TRIM_B: press_b_ff   <= csr_wdata;
            bpc_pkg::REG_PRESS_TRIM_C: press_c_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      trim.t1 = temp_trim_ff[15:0];
      trim.t2 = temp_trim_ff[31:16];
      trim.t3 = temp_trim_ff[47:32];
      trim.p1 = press_a_ff[15:0];
      trim.p2 = press_a_ff[31:16];
      trim.p3 = press_a_ff[47:32];
      trim.p4 = press_b_ff[15:0];
      trim.p5 = press_b_ff[31:16];
      trim.p6 = press_b_ff[47:32];
      trim.p7 = press_c_ff[15:0];
      trim.p8 = press_c_ff[31:16];
      trim.p9 = press_c_ff[47:32];
   end

   // pipeline moves unless the output buffer is full and not draining
   assign adv       = (cnt_ff != bpc_pkg::SKID_FULL) || !rsp_stall;
   assign req_stall = !adv;

   bpc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_vld    (req_valid),
      .in_data   (req_payload),
      .trim      (trim),
      .out_vld   (t_vld),
      .out_tf    (t_tf),
      .out_temp  (t_temp),
      .out_adc_p (t_adc_p)
   );

   bpc_pcoef u_pcoef (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (t_vld),
      .in_tf    (t_tf),
      .in_temp  (t_temp),
      .in_adc_p (t_adc_p),
      .trim     (trim),
      .out_vld  (c_vld),
      .out_num  (c_num),
      .out_den  (c_den),
      .out_temp (c_temp)
   );

   bpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (c_vld),
      .in_num   (c_num),
      .in_den   (c_den),
      .in_temp  (c_temp),
      .out_vld  (d_vld),
      .out_q    (d_q),
      .out_zero (d_zero),
      .out_temp (d_temp)
   );

   bpc_ppost u_ppost (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (d_vld),
      .in_q     (d_q),
      .in_zero  (d_zero),
      .in_temp  (d_temp),
      .trim     (trim),
      .out_vld  (p_vld),
      .out_data (p_data)
   );

   assign push = adv && p_vld;
   assign pop  = (cnt_ff != 2'd0) && !rsp_stall;

   always_comb begin
      cnt_in  = cnt_ff;
      buf0_in = buf0_ff;
      buf1_in = buf1_ff;
      if (push && pop) begin
         if (cnt_ff == bpc_pkg::SKID_FULL) begin
            buf0_in = buf1_ff;
            buf1_in = p_data;
         end else begin
            buf0_in = p_data;
         end
      end else if (pop) begin
         buf0_in = buf1_ff;
         cnt_in  = cnt_ff - 2'd1;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            buf0_in = p_data;
         end else begin
            buf1_in = p_data;
         end
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      buf0_ff <= buf0_in;
      buf1_ff <= buf1_in;
   end

   assign rsp_valid   = (cnt_ff != 2'd0);
   assign rsp_payload = buf0_ff;

endmodule
